### src/hstx_pkg.sv
// Shared types, constants and the escape translation table for the text sanitiser.
package hstx_pkg;

  localparam int PENDING_DEPTH_DEF = 16;
  localparam int MAX_RESULTS       = 20;
  localparam int SYM_Q_DEPTH       = 4;
  localparam int RES_Q_DEPTH       = 4;

  localparam logic [7:0] CH_LT         = 8'h3C;
  localparam logic [7:0] CH_GT         = 8'h3E;
  localparam logic [7:0] CH_B_LO       = 8'h62;
  localparam logic [7:0] CH_B_UP       = 8'h42;
  localparam logic [7:0] CH_R_LO       = 8'h72;
  localparam logic [7:0] CH_R_UP       = 8'h52;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_NL         = 8'h0A;
  localparam logic [7:0] CH_HYPHEN     = 8'h2D;
  localparam logic [7:0] CH_APOS       = 8'h27;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_PERIOD     = 8'h2E;
  localparam logic [7:0] DOT_HI        = 8'hC2;
  localparam logic [7:0] DOT_LO        = 8'hB7;
  localparam logic [7:0] ESC_LEAD      = 8'hE2;
  localparam logic [7:0] ESC_MID       = 8'h80;
  localparam logic [7:0] ESC_SPACE_MAX = 8'h8F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_present;
    logic       out_last;
  } result_t;

  // One request from the front end to the back end
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;   // end of message: flush the escape decoder
    logic       first;    // first request caused by its input item
    logic       fin;      // caused by the final item of the message
  } sym_t;

  // Up to three bytes produced by one request
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] b;
    logic            present;
  } rlist_t;

  typedef enum logic [1:0] {TAG_OUT, TAG_OPEN, TAG_B, TAG_BODY} tag_phase_t;
  typedef enum logic [1:0] {ESC_NONE, ESC_LEAD_HELD, ESC_MID_HELD} esc_phase_t;
  typedef enum logic [1:0] {F_IDLE, F_DRAIN, F_END} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_EMIT, B_FINAL} back_state_t;

  function automatic rlist_t translate(input logic [7:0] x);
    rlist_t r;
    r         = '0;
    r.n       = 2'd1;
    r.present = 1'b1;
    r.b[0]    = CH_HYPHEN;
    if (x <= ESC_SPACE_MAX) begin
      r.b[0] = CH_SPACE;
    end else begin
      unique case (x)
        8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95: r.b[0] = CH_HYPHEN;
        8'h98, 8'h99, 8'h9B: r.b[0] = CH_APOS;
        8'h9A: r.b[0] = CH_COMMA;
        8'h9C, 8'h9D, 8'h9E, 8'h9F: r.b[0] = CH_QUOTE;
        8'hA2, 8'hA3, 8'hA4: begin
          r.n    = 2'd2;
          r.b[0] = DOT_HI;
          r.b[1] = DOT_LO;
        end
        8'hA6: begin
          r.n    = 2'd3;
          r.b[0] = CH_PERIOD;
          r.b[1] = CH_PERIOD;
          r.b[2] = CH_PERIOD;
        end
        default: r.b[0] = CH_HYPHEN;
      endcase
    end
    return r;
  endfunction

endpackage

### src/hstx_fifo.sv
// Small register queue used between the front end, back end and result port.
module hstx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy above depth");

endmodule

### src/hstx_front.sv
// Front end: markup removal and whitespace holding, feeding requests to the back end.
module hstx_front import hstx_pkg::*; #(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  item_t item,
  input  logic  push,
  output logic  full,
  output sym_t  sym,
  output logic  sym_push,
  input  logic  sym_full
);

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  front_state_t             state, state_next;
  tag_phase_t               tag, tag_next, tag_step;
  logic                     brk, brk_next, brk_step;
  logic [PENDING_DEPTH-1:0] ws_kind, ws_kind_next, ws_work;
  logic [CNT_W-1:0]         ws_cnt, ws_cnt_next;
  logic [7:0]               held_c, held_c_next;
  logic                     held_last, held_last_next;
  logic                     sent, sent_next;

  logic                     accept;
  logic                     c_valid;
  logic [7:0]               c_byte;
  logic                     is_ws;
  logic                     ws_full;
  logic [IDX_W-1:0]         wr_pos;
  logic [7:0]               head_ch;
  logic                     go_drain;

  assign full    = (state != F_IDLE) || sym_full;
  assign accept  = push && !full;
  assign ws_full = (ws_cnt == CNT_W'(PENDING_DEPTH));
  assign head_ch = ws_kind[0] ? CH_NL : CH_SPACE;
  assign is_ws   = (c_byte == CH_SPACE) || (c_byte == CH_NL);
  assign wr_pos  = ws_full ? IDX_W'(PENDING_DEPTH - 1) : ws_cnt[IDX_W-1:0];

  // Markup tracking for the incoming byte
  always_comb begin
    tag_step = tag;
    brk_step = brk;
    c_valid  = 1'b0;
    c_byte   = item.data_byte;
    if (item.has_byte) begin
      unique case (tag)
        TAG_OUT: begin
          if (item.data_byte == CH_LT) begin
            tag_step = TAG_OPEN;
            brk_step = 1'b0;
          end else begin
            c_valid = 1'b1;
          end
        end
        TAG_OPEN: begin
          if (item.data_byte == CH_GT) begin
            tag_step = TAG_OUT;
          end else if (item.data_byte == CH_B_LO || item.data_byte == CH_B_UP) begin
            tag_step = TAG_B;
          end else begin
            tag_step = TAG_BODY;
          end
        end
        TAG_B: begin
          if (item.data_byte == CH_GT) begin
            tag_step = TAG_OUT;
          end else begin
            if (item.data_byte == CH_R_LO || item.data_byte == CH_R_UP) begin
              brk_step = 1'b1;
            end
            tag_step = TAG_BODY;
          end
        end
        TAG_BODY: begin
          if (item.data_byte == CH_GT) begin
            if (brk) begin
              c_valid = 1'b1;
              c_byte  = CH_NL;
            end
            tag_step = TAG_OUT;
            brk_step = 1'b0;
          end
        end
      endcase
    end
  end

  // Datapath and request outputs
  always_comb begin
    tag_next       = tag;
    brk_next       = brk;
    ws_kind_next   = ws_kind;
    ws_cnt_next    = ws_cnt;
    held_c_next    = held_c;
    held_last_next = held_last;
    sent_next      = sent;
    sym_push       = 1'b0;
    sym            = '0;
    go_drain       = 1'b0;
    ws_work        = ws_kind;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          tag_next       = item.is_last ? TAG_OUT : tag_step;
          brk_next       = item.is_last ? 1'b0 : brk_step;
          held_last_next = item.is_last;
          sent_next      = 1'b0;
          if (c_valid && is_ws) begin
            // store full: pass the oldest byte on before taking the new one
            if (ws_full) begin
              sym_push  = 1'b1;
              sym.ch    = head_ch;
              sym.first = 1'b1;
              sym.fin   = item.is_last;
              sent_next = 1'b1;
              ws_work   = ws_kind >> 1;
            end else begin
              ws_cnt_next = ws_cnt + CNT_W'(1);
            end
            ws_work[wr_pos] = (c_byte == CH_NL);
            ws_kind_next    = ws_work;
          end else if (c_valid) begin
            if (ws_cnt == '0) begin
              sym_push  = 1'b1;
              sym.ch    = c_byte;
              sym.first = 1'b1;
              sym.fin   = item.is_last;
              sent_next = 1'b1;
            end else begin
              held_c_next = c_byte;
              go_drain    = 1'b1;
            end
          end
          // drop held whitespace at the end of the message
          if (item.is_last && !go_drain) begin
            ws_cnt_next = '0;
          end
        end
      end
      F_DRAIN: begin
        if (!sym_full) begin
          sym_push  = 1'b1;
          sym.first = !sent;
          sym.fin   = held_last;
          sent_next = 1'b1;
          if (ws_cnt != '0) begin
            sym.ch       = head_ch;
            ws_kind_next = ws_kind >> 1;
            ws_cnt_next  = ws_cnt - CNT_W'(1);
          end else begin
            sym.ch = held_c;
          end
        end
      end
      F_END: begin
        if (!sym_full) begin
          sym_push   = 1'b1;
          sym.is_end = 1'b1;
          sym.first  = !sent;
          sym.fin    = 1'b1;
          sent_next  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (go_drain) begin
            state_next = F_DRAIN;
          end else if (item.is_last) begin
            state_next = F_END;
          end
        end
      end
      F_DRAIN: begin
        if (!sym_full && ws_cnt == '0) begin
          state_next = held_last ? F_END : F_IDLE;
        end
      end
      F_END: begin
        if (!sym_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      tag       <= TAG_OUT;
      brk       <= 1'b0;
      ws_cnt    <= '0;
      held_last <= 1'b0;
      sent      <= 1'b0;
    end else begin
      state     <= state_next;
      tag       <= tag_next;
      brk       <= brk_next;
      ws_cnt    <= ws_cnt_next;
      held_last <= held_last_next;
      sent      <= sent_next;
    end
  end

  always_ff @(posedge clk) begin
    ws_kind <= ws_kind_next;
    held_c  <= held_c_next;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    sym_push |-> !sym_full)
    else $error("request pushed into a full queue");

  a_ws_bound: assert property (@(posedge clk) disable iff (rst)
    ws_cnt <= CNT_W'(PENDING_DEPTH))
    else $error("whitespace count above store depth");

endmodule

### src/hstx_back.sv
// Back end: escape translation, per-item result cap and end-of-message marking.
module hstx_back import hstx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  sym_t    sym,
  input  logic    sym_valid,
  output logic    sym_pop,
  output result_t res,
  output logic    res_push,
  input  logic    res_full
);

  localparam int RC_W = $clog2(MAX_RESULTS + 1);

  back_state_t state, state_next;
  esc_phase_t  esc, esc_next, esc_take;
  logic        emitted_any, emitted_any_next;
  logic [RC_W-1:0] res_cnt, res_cnt_next, cnt_base;
  rlist_t      lst_in, lst, lst_next;
  logic [1:0]  idx, idx_next;
  logic        cur_end, cur_end_next;
  logic        cur_fin, cur_fin_next;
  logic [7:0]  pend_byte, pend_byte_next;
  logic        pend_present, pend_present_next;
  logic        pend_v, pend_v_next;

  logic        take;
  logic        advance;
  logic        emit_req;
  logic [7:0]  emit_byte;
  logic        emit_present;
  logic        emit_fin;
  logic        keep;

  // Results of the request at the head of the queue
  always_comb begin
    lst_in         = '0;
    lst_in.present = 1'b1;
    esc_take       = ESC_NONE;
    if (sym.is_end) begin
      unique case (esc)
        ESC_LEAD_HELD: begin
          lst_in.n    = 2'd1;
          lst_in.b[0] = ESC_LEAD;
        end
        ESC_MID_HELD: begin
          lst_in.n    = 2'd2;
          lst_in.b[0] = ESC_LEAD;
          lst_in.b[1] = ESC_MID;
        end
        default: begin
          // nothing came out for this message: send the marker
          if (!emitted_any) begin
            lst_in.n       = 2'd1;
            lst_in.present = 1'b0;
          end
        end
      endcase
    end else begin
      unique case (esc)
        ESC_MID_HELD: lst_in = translate(sym.ch);
        ESC_LEAD_HELD: begin
          if (sym.ch == ESC_MID) begin
            esc_take = ESC_MID_HELD;
          end else if (sym.ch == ESC_LEAD) begin
            lst_in.n    = 2'd1;
            lst_in.b[0] = ESC_LEAD;
            esc_take    = ESC_LEAD_HELD;
          end else begin
            lst_in.n    = 2'd2;
            lst_in.b[0] = ESC_LEAD;
            lst_in.b[1] = sym.ch;
          end
        end
        default: begin
          if (sym.ch == ESC_LEAD) begin
            esc_take = ESC_LEAD_HELD;
          end else begin
            lst_in.n    = 2'd1;
            lst_in.b[0] = sym.ch;
          end
        end
      endcase
    end
  end

  assign take    = (state == B_IDLE) && sym_valid && !res_full;
  assign advance = !res_full;
  assign sym_pop = take;
  assign keep    = cnt_base < RC_W'(MAX_RESULTS);

  // Result emission through the hold register
  always_comb begin
    esc_next          = esc;
    emitted_any_next  = emitted_any;
    lst_next          = lst;
    idx_next          = idx;
    cur_end_next      = cur_end;
    cur_fin_next      = cur_fin;
    pend_byte_next    = pend_byte;
    pend_present_next = pend_present;
    pend_v_next       = pend_v;
    cnt_base          = res_cnt;
    emit_req          = 1'b0;
    emit_byte         = lst.b[idx];
    emit_present      = lst.present;
    emit_fin          = cur_fin;
    res_push          = 1'b0;
    res               = '0;
    unique case (state)
      B_IDLE: begin
        if (take) begin
          cnt_base         = sym.first ? '0 : res_cnt;
          emit_req         = (lst_in.n != 2'd0);
          emit_byte        = lst_in.b[0];
          emit_present     = lst_in.present;
          emit_fin         = sym.fin;
          esc_next         = esc_take;
          emitted_any_next = !sym.is_end && (emitted_any || lst_in.n != 2'd0);
          lst_next         = lst_in;
          idx_next         = 2'd1;
          cur_end_next     = sym.is_end;
          cur_fin_next     = sym.fin;
        end
      end
      B_EMIT: begin
        emit_req = advance;
        if (advance) begin
          idx_next = idx + 2'd1;
        end
      end
      B_FINAL: begin
        if (pend_v && advance) begin
          res_push      = 1'b1;
          res.out_byte    = pend_byte;
          res.out_present = pend_present;
          res.out_last    = 1'b1;
          pend_v_next     = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res_cnt_next = cnt_base;
    if (emit_req && keep) begin
      res_cnt_next = cnt_base + RC_W'(1);
      if (emit_fin) begin
        // hold the newest result of the final item until its last flag is known
        if (pend_v) begin
          res_push        = 1'b1;
          res.out_byte    = pend_byte;
          res.out_present = pend_present;
        end
        pend_byte_next    = emit_byte;
        pend_present_next = emit_present;
        pend_v_next       = 1'b1;
      end else begin
        res_push        = 1'b1;
        res.out_byte    = emit_byte;
        res.out_present = emit_present;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (take) begin
          if (lst_in.n > 2'd1) begin
            state_next = B_EMIT;
          end else if (sym.is_end) begin
            state_next = B_FINAL;
          end
        end
      end
      B_EMIT: begin
        if (advance && idx == lst.n - 2'd1) begin
          state_next = cur_end ? B_FINAL : B_IDLE;
        end
      end
      B_FINAL: begin
        if (advance || !pend_v) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      esc         <= ESC_NONE;
      emitted_any <= 1'b0;
      res_cnt     <= '0;
      pend_v      <= 1'b0;
      idx         <= 2'd0;
      cur_end     <= 1'b0;
      cur_fin     <= 1'b0;
    end else begin
      state       <= state_next;
      esc         <= esc_next;
      emitted_any <= emitted_any_next;
      res_cnt     <= res_cnt_next;
      pend_v      <= pend_v_next;
      idx         <= idx_next;
      cur_end     <= cur_end_next;
      cur_fin     <= cur_fin_next;
    end
  end

  always_ff @(posedge clk) begin
    lst          <= lst_next;
    pend_byte    <= pend_byte_next;
    pend_present <= pend_present_next;
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result written into a full queue");

  a_hold_only_in_final: assert property (@(posedge clk) disable iff (rst)
    (take && !sym.fin) |-> !pend_v)
    else $error("held result outlived its message");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RC_W'(MAX_RESULTS))
    else $error("per-item result count above cap");

endmodule

### src/html_strip_text_sanitizer.sv
// Path: a result byte is registered in the request queue and then in the result queue;
// the last result of the final item is held back until the end-of-message request is taken.
// Throughput: one byte per cycle when not stalled; input stalls while held whitespace is
// released or a message end is sent, and a multi-byte escape holds up the back end.
// Reset: synchronous, active high; clears control state and both queues, the whitespace
// store contents are left as they are.
module html_strip_text_sanitizer import hstx_pkg::*; #(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    push,
  output logic    full,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  sym_t    sym_w;
  sym_t    sym_r;
  logic    sym_wr;
  logic    sym_full;
  logic    sym_empty;
  logic    sym_rd;
  result_t res_w;
  logic    res_wr;
  logic    res_full;

  hstx_front #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .push     (push),
    .full     (full),
    .sym      (sym_w),
    .sym_push (sym_wr),
    .sym_full (sym_full)
  );

  hstx_fifo #(
    .WIDTH($bits(sym_t)),
    .DEPTH(SYM_Q_DEPTH)
  ) u_sym_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (sym_wr),
    .wr_data (sym_w),
    .full    (sym_full),
    .rd_en   (sym_rd),
    .rd_data (sym_r),
    .empty   (sym_empty)
  );

  hstx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .sym       (sym_r),
    .sym_valid (!sym_empty),
    .sym_pop   (sym_rd),
    .res       (res_w),
    .res_push  (res_wr),
    .res_full  (res_full)
  );

  hstx_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RES_Q_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_w),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule

### bench/tb_html_strip_text_sanitizer.sv
// Self-checking bench for the text sanitiser: predicts each cleaned byte and checks the stream.
`timescale 1ns / 100ps

module tb_html_strip_text_sanitizer;
  import hstx_pkg::*;

  localparam int WS_DEPTH     = PENDING_DEPTH_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 50;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  item_t   item  = '0;
  logic    push  = 1'b0;
  logic    full;
  result_t result;
  logic    empty;
  logic    pop   = 1'b0;

  int   tx_gap_pct   = 0;
  int   rx_stall_pct = 0;
  logic pop_held     = 1'b0;
  event hold_pop;

  int mismatches = 0;
  int real_items = 0;

  item_t msg_items[$];

  // Predicted text state
  tag_phase_t tag_st;
  logic       brk_tag;
  logic       ws_is_nl [WS_DEPTH];
  int         ws_count;
  esc_phase_t esc_st;
  logic       any_out;
  int         step_n;
  result_t    expected_out[$];

  html_strip_text_sanitizer #(.PENDING_DEPTH(WS_DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .push   (push),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_text_state();
    tag_st   = TAG_OUT;
    brk_tag  = 1'b0;
    ws_count = 0;
    esc_st   = ESC_NONE;
    any_out  = 1'b0;
  endfunction

  function automatic void put_out(logic [7:0] b);
    expected_out.push_back('{out_byte: b, out_present: 1'b1, out_last: 1'b0});
    any_out = 1'b1;
    step_n++;
  endfunction

  function automatic void expand_escape(logic [7:0] x);
    if (x <= ESC_SPACE_MAX) begin
      put_out(CH_SPACE);
    end else begin
      case (x)
        8'h98, 8'h99, 8'h9B: put_out(CH_APOS);
        8'h9A: put_out(CH_COMMA);
        8'h9C, 8'h9D, 8'h9E, 8'h9F: put_out(CH_QUOTE);
        8'hA2, 8'hA3, 8'hA4: begin
          put_out(DOT_HI);
          put_out(DOT_LO);
        end
        8'hA6: begin
          repeat (3) put_out(CH_PERIOD);
        end
        default: put_out(CH_HYPHEN);
      endcase
    end
  endfunction

  function automatic void decode_esc(logic [7:0] c);
    if (esc_st == ESC_MID_HELD) begin
      expand_escape(c);
      esc_st = ESC_NONE;
      return;
    end
    if (esc_st == ESC_LEAD_HELD) begin
      if (c == ESC_MID) begin
        esc_st = ESC_MID_HELD;
        return;
      end
      put_out(ESC_LEAD);
      esc_st = ESC_NONE;
    end
    if (c == ESC_LEAD) esc_st = ESC_LEAD_HELD;
    else put_out(c);
  endfunction

  function automatic void hold_ws(logic [7:0] c);
    if (c == CH_SPACE || c == CH_NL) begin
      // store full: pass the oldest byte on before taking the new one
      if (ws_count >= WS_DEPTH) begin
        decode_esc(ws_is_nl[0] ? CH_NL : CH_SPACE);
        for (int i = 1; i < WS_DEPTH; i++) ws_is_nl[i - 1] = ws_is_nl[i];
        ws_count = WS_DEPTH - 1;
      end
      ws_is_nl[ws_count] = (c == CH_NL);
      ws_count++;
    end else begin
      for (int i = 0; i < ws_count; i++) decode_esc(ws_is_nl[i] ? CH_NL : CH_SPACE);
      ws_count = 0;
      decode_esc(c);
    end
  endfunction

  function automatic void strip_tag(logic [7:0] c);
    case (tag_st)
      TAG_OUT: begin
        if (c == CH_LT) begin
          tag_st  = TAG_OPEN;
          brk_tag = 1'b0;
        end else begin
          hold_ws(c);
        end
      end
      TAG_OPEN: begin
        if (c == CH_GT) tag_st = TAG_OUT;
        else if (c == CH_B_LO || c == CH_B_UP) tag_st = TAG_B;
        else tag_st = TAG_BODY;
      end
      TAG_B: begin
        if (c == CH_GT) begin
          tag_st = TAG_OUT;
        end else begin
          if (c == CH_R_LO || c == CH_R_UP) brk_tag = 1'b1;
          tag_st = TAG_BODY;
        end
      end
      default: begin
        if (c == CH_GT) begin
          if (brk_tag) hold_ws(CH_NL);
          tag_st  = TAG_OUT;
          brk_tag = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic void sanitise_item(item_t it);
    result_t tail;
    step_n = 0;
    if (it.has_byte) strip_tag(it.data_byte);
    if (it.is_last) begin
      // drop trailing whitespace, release a partial escape raw
      ws_count = 0;
      if (esc_st != ESC_NONE) put_out(ESC_LEAD);
      if (esc_st == ESC_MID_HELD) put_out(ESC_MID);
      if (!any_out) begin
        expected_out.push_back('{out_byte: 8'h00, out_present: 1'b0, out_last: 1'b0});
        step_n++;
      end
      if (step_n > 0) begin
        tail          = expected_out[expected_out.size() - 1];
        tail.out_last = 1'b1;
        expected_out[expected_out.size() - 1] = tail;
      end
      clear_text_state();
    end
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatches < MAX_REPORTS) $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (expected_out.size() == 0) begin
      flag_mismatch($sformatf("result %h with nothing expected", got));
      return;
    end
    want = expected_out.pop_front();
    if (got.out_byte !== want.out_byte)
      flag_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
    if (got.out_present !== want.out_present)
      flag_mismatch($sformatf("out_present %b, expected %b", got.out_present,
                              want.out_present));
    if (got.out_last !== want.out_last)
      flag_mismatch($sformatf("out_last %b, expected %b", got.out_last, want.out_last));
  endtask

  // Predict on every accepted request, check every popped result
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sanitise_item(item);
      if (pop && !empty) check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || pop_held) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= rx_stall_pct);
  end

  always begin
    @(hold_pop);
    @(posedge clk);
    pop_held <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    pop_held <= 1'b0;
  end

  task automatic send_req(item_t it);
    while ($urandom_range(99) < tx_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic queue_item(logic [7:0] b, logic has, logic last);
    msg_items.push_back('{data_byte: b, has_byte: has, is_last: last});
  endtask

  task automatic queue_byte(logic [7:0] b);
    queue_item(b, 1'b1, 1'b0);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  task automatic send_msg();
    foreach (msg_items[i]) begin
      send_req(msg_items[i]);
      if (msg_items[i].has_byte || msg_items[i].is_last) real_items++;
    end
    msg_items.delete();
  endtask

  task automatic build_random_msg();
    int    n_tok;
    item_t tail;
    n_tok = $urandom_range(1, 8);
    if ($urandom_range(19) != 0) begin
      repeat (n_tok) begin
        case ($urandom_range(9))
          0, 1: begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(8'h21, 8'h7E)));
          end
          2: queue_byte(8'($urandom_range(255)));
          3: begin
            repeat ($urandom_range(1, 20)) queue_byte($urandom_range(1) ? CH_NL : CH_SPACE);
          end
          4, 5: begin
            queue_byte(ESC_LEAD);
            queue_byte(ESC_MID);
            if ($urandom_range(7) == 0) queue_byte(8'($urandom_range(255)));
            else queue_byte(8'($urandom_range(8'h80, 8'hAF)));
          end
          6: begin
            // partial escape: whatever comes next breaks or completes it
            queue_byte(ESC_LEAD);
            if ($urandom_range(1)) queue_byte(ESC_MID);
          end
          7: begin
            queue_byte(CH_LT);
            if ($urandom_range(2) != 0) queue_byte($urandom_range(1) ? CH_B_LO : CH_B_UP);
            else queue_byte(8'($urandom_range(8'h21, 8'h7E)));
            if ($urandom_range(2) != 0) queue_byte($urandom_range(1) ? CH_R_LO : CH_R_UP);
            else queue_byte(8'($urandom_range(8'h21, 8'h7E)));
            repeat ($urandom_range(2)) queue_byte(8'($urandom_range(8'h21, 8'h7E)));
            if ($urandom_range(4) != 0) queue_byte(CH_GT);
          end
          8: queue_item(8'($urandom_range(255)), 1'b0, 1'b0);
          default: queue_byte(CH_SPACE);
        endcase
      end
    end
    if (msg_items.size() == 0 || $urandom_range(5) == 0) begin
      queue_item(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      tail         = msg_items[msg_items.size() - 1];
      tail.is_last = 1'b1;
      msg_items[msg_items.size() - 1] = tail;
    end
  endtask

  task automatic run_random(int tx_pct, int rx_pct, int n_items);
    int start;
    tx_gap_pct   = tx_pct;
    rx_stall_pct = rx_pct;
    start        = real_items;
    while (real_items - start < n_items) begin
      build_random_msg();
      send_msg();
    end
  endtask

  task automatic test_directed();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    // empty message gives the marker alone
    queue_item(8'h00, 1'b0, 1'b1);
    send_msg();
    // break tag still open at the end: it gives no newline, so only the marker
    queue_text("<br");
    queue_item(8'h00, 1'b0, 1'b1);
    send_msg();
    // extremes, a closed break tag, ellipsis and dot escapes, idle item, partial escape
    queue_byte(8'h00);
    queue_text("<BR>a");
    queue_byte(ESC_LEAD);
    queue_byte(ESC_MID);
    queue_byte(8'hA6);
    queue_byte(ESC_LEAD);
    queue_byte(ESC_MID);
    queue_byte(8'hA2);
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF);
    queue_byte(ESC_LEAD);
    queue_item(ESC_MID, 1'b1, 1'b1);
    send_msg();
  endtask

  task automatic test_no_idle();
    run_random(0, 0, 70);
  endtask

  task automatic test_sender_idle();
    run_random(62, 0, 70);
  endtask

  task automatic test_receiver_stall();
    run_random(0, 62, 70);
  endtask

  task automatic test_both_idle();
    run_random(37, 37, 70);
  endtask

  // Hold the receiver off while a long message with an overlong whitespace run goes in
  task automatic test_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    -> hold_pop;
    queue_text("hold");
    repeat (20) queue_byte($urandom_range(1) ? CH_NL : CH_SPACE);
    queue_byte(ESC_LEAD);
    queue_byte(ESC_MID);
    queue_byte(8'hA6);
    queue_text("released after a long stall");
    queue_item(8'h21, 1'b1, 1'b1);
    send_msg();
  endtask

  initial begin
    clear_text_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_no_idle();
    test_backpressure();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    push         <= 1'b0;
    rx_stall_pct = 0;
    @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("tb_html_strip_text_sanitizer passed");
    end else begin
      $display("tb_html_strip_text_sanitizer failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_html_strip_text_sanitizer failed");
    $finish;
  end

endmodule

### files.f
src/hstx_pkg.sv
src/hstx_fifo.sv
src/hstx_front.sv
src/hstx_back.sv
src/html_strip_text_sanitizer.sv
bench/tb_html_strip_text_sanitizer.sv
